>>> hdl/icy_md_pkg.sv
// Shared types, codes and key table for the ICY metadata de-interleaver.
package icy_md_pkg;

  // Field widths fixed by the interface
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned METAINT_W = 21;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Most results one input byte can give
  localparam int unsigned MAX_RES = 3;

  // Result queue depth; must hold MAX_RES plus one in flight
  localparam int unsigned QDEPTH = 4;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;

  // Length of the key StreamTitle='
  localparam int unsigned KEY_LEN = 13;

  // One result
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
  } res_t;

  // All results of one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]             count;
    res_t [MAX_RES-1:0]     slot;
  } step_t;

  // Key character at a given position
  function automatic logic [BYTE_W-1:0] key_char(input logic [3:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = 8'h27; // '
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/icy_metadata_deinterleaver.sv
// Top level of the ICY in-band metadata de-interleaver.
//
// Input channel: one raw stream byte per transaction (in_valid_i/in_ready_o).
// Output channel: one result per transaction (out_valid_o/out_ready_i):
// an audio byte, a title text byte, or an end-of-title marker with byte 0.
// last_of_run_o flags the final result caused by one input byte; a byte may
// give none (length byte, swallowed metadata), one, or up to three results.
// cfg_we_i/cfg_wdata_i write the metadata interval; zero, or a value above
// METAINT_LIMIT, gives pure passthrough. A write restarts framing, so write
// only while no bytes are in flight.
// Results of a byte are queued in registers, valid the cycle after acceptance.
// The block takes one byte per cycle while each byte gives at most one result
// and the receiver takes every cycle; the four-entry result queue sets this,
// taking a byte only while three or more entries are free, so bytes giving
// several results hold the input until the queue drains.
// When the receiver stalls, results wait in the queue and the input stops
// once it holds two results. Reset empties the queue, clears the interval to
// zero (passthrough) and returns framing to the audio phase.
module icy_metadata_deinterleaver #(
  parameter int unsigned UNIT_BYTES    = 16,
  parameter int unsigned METAINT_LIMIT = 1048576
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icy_md_pkg::METAINT_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [icy_md_pkg::BYTE_W-1:0]     in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [icy_md_pkg::KIND_W-1:0]     kind_o,
  output logic [icy_md_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                              last_of_run_o
);

  icy_md_pkg::step_t step;
  logic              in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // Per-byte parsing
  icy_md_parser #(
    .UNIT_BYTES    (UNIT_BYTES),
    .METAINT_LIMIT (METAINT_LIMIT)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_en_i   (in_fire),
    .in_byte_i   (in_byte_i),
    .step_o      (step)
  );

  // Result queue
  icy_md_resq u_resq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (in_fire),
    .step_i        (step),
    .room_o        (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // A byte with results makes the output valid next cycle
  a_results_appear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step.count != 2'd0 |=> out_valid_o)
    else $error("results of an accepted byte not presented");

  // Input only stalls while results are pending
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result queue");

  // End of title carries a zero byte and closes the run
  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == icy_md_pkg::KIND_END |-> out_byte_o == '0 && last_of_run_o)
    else $error("malformed end-of-title marker");

  // Three results from one byte always start with text
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> step.count != 2'd3 || step.slot[0].kind == icy_md_pkg::KIND_TEXT)
    else $error("three results without leading text");

endmodule

>>> hdl/icy_md_parser.sv
// Stream parser: framing state, key search and title extraction per byte.
module icy_md_parser #(
  parameter int unsigned UNIT_BYTES    = 16,
  parameter int unsigned METAINT_LIMIT = 1048576
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [icy_md_pkg::METAINT_W-1:0]    cfg_wdata_i,
  input  logic                                step_en_i,
  input  logic [icy_md_pkg::BYTE_W-1:0]       in_byte_i,
  output icy_md_pkg::step_t                   step_o
);

  localparam int unsigned ML_W = $clog2(255 * UNIT_BYTES + 1);

  // Framing phase codes
  localparam logic [1:0] PH_AUDIO  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_META   = 2'd2;

  // Title phase codes
  localparam logic [1:0] TP_SEARCH = 2'd0;
  localparam logic [1:0] TP_TITLE  = 2'd1;
  localparam logic [1:0] TP_DONE   = 2'd2;

  logic [icy_md_pkg::METAINT_W-1:0] iv_q, iv_wr;
  logic [icy_md_pkg::METAINT_W-1:0] audio_left_q, audio_left_d;
  logic [1:0]                       phase_q, phase_d;
  logic [ML_W-1:0]                  meta_left_q, meta_left_d;
  logic [ML_W-1:0]                  len_bytes;
  logic [3:0]                       key_pos_q, key_pos_d;
  logic [1:0]                       title_phase_q, title_phase_d;
  logic                             quote_held_q, quote_held_d;
  logic [1:0]                       n;
  icy_md_pkg::res_t [icy_md_pkg::MAX_RES-1:0] s;
  logic                             b_is_semi, b_is_quote;

  // Implausible intervals mean passthrough
  assign iv_wr = (32'(cfg_wdata_i) > 32'(METAINT_LIMIT)) ? '0 : cfg_wdata_i;

  assign len_bytes  = ML_W'(in_byte_i) * ML_W'(UNIT_BYTES);
  assign b_is_semi  = (in_byte_i == icy_md_pkg::CHAR_SEMI);
  assign b_is_quote = (in_byte_i == icy_md_pkg::CHAR_QUOTE);

  // Next state and results for the byte on the input
  always_comb begin
    audio_left_d  = audio_left_q;
    phase_d       = phase_q;
    meta_left_d   = meta_left_q;
    key_pos_d     = key_pos_q;
    title_phase_d = title_phase_q;
    quote_held_d  = quote_held_q;
    n             = '0;
    s             = '0;

    if (iv_q == '0) begin
      s[0] = '{kind: icy_md_pkg::KIND_AUDIO, data: in_byte_i};
      n    = 2'd1;
    end else begin
      case (phase_q)
        PH_AUDIO: begin
          s[0] = '{kind: icy_md_pkg::KIND_AUDIO, data: in_byte_i};
          n    = 2'd1;
          if (audio_left_q != '0) audio_left_d = audio_left_q - 1'b1;
          if (audio_left_d == '0) phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          meta_left_d   = len_bytes;
          key_pos_d     = '0;
          title_phase_d = TP_SEARCH;
          quote_held_d  = 1'b0;
          if (len_bytes == '0) begin
            phase_d      = PH_AUDIO;
            audio_left_d = iv_q;
          end else begin
            phase_d = PH_META;
          end
        end
        PH_META: begin
          case (title_phase_q)
            TP_SEARCH: begin
              if (key_pos_q < 4'(icy_md_pkg::KEY_LEN) &&
                  in_byte_i == icy_md_pkg::key_char(key_pos_q)) begin
                key_pos_d = key_pos_q + 4'd1;
              end else begin
                key_pos_d = (in_byte_i == icy_md_pkg::CHAR_S) ? 4'd1 : 4'd0;
              end
              if (key_pos_d >= 4'(icy_md_pkg::KEY_LEN)) title_phase_d = TP_TITLE;
            end
            TP_TITLE: begin
              // a held quote resolves against this byte
              if (quote_held_q) begin
                quote_held_d = 1'b0;
                if (b_is_semi) begin
                  title_phase_d = TP_DONE;
                  s[n] = '{kind: icy_md_pkg::KIND_END, data: '0};
                  n    = n + 2'd1;
                end else begin
                  s[n] = '{kind: icy_md_pkg::KIND_TEXT, data: icy_md_pkg::CHAR_QUOTE};
                  n    = n + 2'd1;
                end
              end
              if (!(quote_held_q && b_is_semi)) begin
                if (b_is_quote) begin
                  quote_held_d = 1'b1;
                end else begin
                  s[n] = '{kind: icy_md_pkg::KIND_TEXT, data: in_byte_i};
                  n    = n + 2'd1;
                end
              end
            end
            default: ;
          endcase
          if (meta_left_q != '0) meta_left_d = meta_left_q - 1'b1;
          // block end closes an open title
          if (meta_left_d == '0) begin
            if (title_phase_d == TP_TITLE) begin
              quote_held_d  = 1'b0;
              title_phase_d = TP_DONE;
              s[n] = '{kind: icy_md_pkg::KIND_END, data: '0};
              n    = n + 2'd1;
            end
            phase_d      = PH_AUDIO;
            audio_left_d = iv_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign step_o.count = n;
  assign step_o.slot  = s;

  // State registers; a register write restarts framing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q          <= '0;
      audio_left_q  <= '0;
      phase_q       <= PH_AUDIO;
      meta_left_q   <= '0;
      key_pos_q     <= '0;
      title_phase_q <= TP_SEARCH;
      quote_held_q  <= 1'b0;
    end else if (cfg_we_i) begin
      iv_q          <= iv_wr;
      audio_left_q  <= iv_wr;
      phase_q       <= PH_AUDIO;
      meta_left_q   <= '0;
      key_pos_q     <= '0;
      title_phase_q <= TP_SEARCH;
      quote_held_q  <= 1'b0;
    end else if (step_en_i) begin
      audio_left_q  <= audio_left_d;
      phase_q       <= phase_d;
      meta_left_q   <= meta_left_d;
      key_pos_q     <= key_pos_d;
      title_phase_q <= title_phase_d;
      quote_held_q  <= quote_held_d;
    end
  end

endmodule

>>> hdl/icy_md_resq.sv
// Result queue: takes up to three results per cycle, hands out one per cycle.
module icy_md_resq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  icy_md_pkg::step_t                 step_i,
  output logic                              room_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [icy_md_pkg::KIND_W-1:0]     kind_o,
  output logic [icy_md_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                              last_of_run_o
);

  localparam int unsigned PTR_W = $clog2(icy_md_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(icy_md_pkg::QDEPTH + 1);

  typedef struct packed {
    icy_md_pkg::res_t res;
    logic             last;
  } entry_t;

  entry_t             mem_q [icy_md_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n = push_i ? step_i.count : 2'd0;
  assign pop    = out_valid_o && out_ready_i;

  // Room for a worst-case byte
  assign room_o  = (count_q <= CNT_W'(icy_md_pkg::QDEPTH - icy_md_pkg::MAX_RES));
  assign count_d = count_q + CNT_W'(push_n) - CNT_W'(pop);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      count_q  <= count_d;
    end
  end

  // Storage; last flag marks the final result of the byte
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < icy_md_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= '{res: step_i.slot[i],
                                         last: (2'(i) == push_n - 2'd1)};
      end
    end
  end

  assign out_valid_o   = (count_q != '0);
  assign kind_o        = mem_q[rd_ptr_q].res.kind;
  assign out_byte_o    = mem_q[rd_ptr_q].res.data;
  assign last_of_run_o = mem_q[rd_ptr_q].last;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the ICY metadata de-interleaver: directed and random stream bytes.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned UNIT_BYTES     = 16;
  localparam int unsigned METAINT_LIMIT  = 1048576;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles for a byte with no result to clear the block
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam logic [icy_md_pkg::BYTE_W-1:0] CHAR_DASH = 8'h2D;
  localparam logic [8*icy_md_pkg::KEY_LEN-1:0] TITLE_KEY = "StreamTitle='";
  localparam logic [8*16-1:0] TITLE_BLOCK = "StreamTitle='x';";

  typedef enum logic [1:0] {FR_AUDIO, FR_LENGTH, FR_META} framing_e;
  typedef enum logic [1:0] {TS_SEARCH, TS_TITLE, TS_DONE} title_state_e;

  // How a generated metadata block is laid out around the key
  typedef enum int unsigned {
    BLK_NO_KEY,
    BLK_EMPTY_TITLE,
    BLK_KEY_AT_END,
    BLK_REPEATED_KEY,
    BLK_QUOTE_AT_END,
    BLK_QUOTE_THEN_TEXT,
    BLK_PLAIN,
    BLK_RESTARTED_KEY
  } block_shape_e;

  typedef struct packed {
    logic [icy_md_pkg::KIND_W-1:0] kind;
    logic [icy_md_pkg::BYTE_W-1:0] data;
    logic                          last;
  } stream_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [icy_md_pkg::METAINT_W-1:0] cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [icy_md_pkg::BYTE_W-1:0]    in_byte_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [icy_md_pkg::KIND_W-1:0]    kind_o;
  logic [icy_md_pkg::BYTE_W-1:0]    out_byte_o;
  logic                             last_of_run_o;

  // Shadow of the block's framing state
  logic [icy_md_pkg::METAINT_W-1:0] interval_reg;
  logic [icy_md_pkg::METAINT_W-1:0] audio_left;
  framing_e                         framing;
  logic [11:0]                      meta_left;
  logic [3:0]                       key_pos;
  title_state_e                     title_state;
  logic                             quote_held;

  stream_result_t pending_results[$];
  stream_result_t byte_results[$];

  int unsigned mismatches        = 0;
  int unsigned sent_count        = 0;
  int unsigned stalled_cycles    = 0;
  int unsigned sink_hold_request = 0;
  bit          quiet             = 1'b0;
  bit          sender_eager      = 1'b0;
  bit          sender_jitter     = 1'b1;
  bit          sink_jitter       = 1'b1;

  icy_metadata_deinterleaver #(
    .UNIT_BYTES   (UNIT_BYTES),
    .METAINT_LIMIT(METAINT_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // Implausibly large intervals fall back to passthrough
  function automatic logic [icy_md_pkg::METAINT_W-1:0] active_interval();
    return (interval_reg > METAINT_LIMIT) ? '0 : interval_reg;
  endfunction

  function automatic void restart_framing();
    audio_left  = active_interval();
    framing     = FR_AUDIO;
    meta_left   = '0;
    key_pos     = '0;
    title_state = TS_SEARCH;
    quote_held  = 1'b0;
  endfunction

  function automatic void queue_result(input logic [icy_md_pkg::KIND_W-1:0] kind,
                                       input logic [icy_md_pkg::BYTE_W-1:0] data);
    byte_results.push_back('{kind: kind, data: data, last: 1'b0});
  endfunction

  // Works out the results of one accepted stream byte
  function automatic void predict_stream_byte(input logic [icy_md_pkg::BYTE_W-1:0] b);
    logic [icy_md_pkg::METAINT_W-1:0] iv;
    iv = active_interval();
    byte_results.delete();
    if (iv == 0) begin
      queue_result(icy_md_pkg::KIND_AUDIO, b);
    end else begin
      case (framing)
        FR_AUDIO: begin
          queue_result(icy_md_pkg::KIND_AUDIO, b);
          if (audio_left != 0) audio_left--;
          if (audio_left == 0) framing = FR_LENGTH;
        end
        FR_LENGTH: begin
          meta_left   = 12'(b * UNIT_BYTES);
          key_pos     = '0;
          title_state = TS_SEARCH;
          quote_held  = 1'b0;
          if (meta_left == 0) begin
            framing    = FR_AUDIO;
            audio_left = iv;
          end else begin
            framing = FR_META;
          end
        end
        default: begin
          // Key search, then title text with a quote held back one byte
          case (title_state)
            TS_SEARCH: begin
              if (key_pos < icy_md_pkg::KEY_LEN &&
                  b == TITLE_KEY[8*(icy_md_pkg::KEY_LEN-1-int'(key_pos)) +: 8])
                key_pos++;
              else
                key_pos = (b == icy_md_pkg::CHAR_S) ? 4'd1 : 4'd0;
              if (key_pos >= icy_md_pkg::KEY_LEN) title_state = TS_TITLE;
            end
            TS_TITLE: begin
              if (quote_held && b == icy_md_pkg::CHAR_SEMI) begin
                quote_held  = 1'b0;
                title_state = TS_DONE;
                queue_result(icy_md_pkg::KIND_END, '0);
              end else begin
                if (quote_held) begin
                  quote_held = 1'b0;
                  queue_result(icy_md_pkg::KIND_TEXT, icy_md_pkg::CHAR_QUOTE);
                end
                if (b == icy_md_pkg::CHAR_QUOTE) quote_held = 1'b1;
                else queue_result(icy_md_pkg::KIND_TEXT, b);
              end
            end
            default: ;
          endcase
          if (meta_left != 0) meta_left--;
          // Block end closes an open title
          if (meta_left == 0) begin
            if (title_state == TS_TITLE) begin
              quote_held  = 1'b0;
              title_state = TS_DONE;
              queue_result(icy_md_pkg::KIND_END, '0);
            end
            framing    = FR_AUDIO;
            audio_left = iv;
          end
        end
      endcase
    end
    if (byte_results.size() != 0) byte_results[byte_results.size()-1].last = 1'b1;
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : result_check
    stream_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%02h last %0b",
               kind_o, out_byte_o, last_of_run_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind_o);
          mismatches++;
        end
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_byte_o);
          mismatches++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run_o);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when no transaction moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Receiver: random stall bursts, calm stretches, and long holds on request
  initial begin : sink
    int unsigned gap;
    int unsigned cycle;
    gap   = 0;
    cycle = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 64 == 0) sink_jitter = ($urandom_range(0, 2) != 0);
      if (sink_hold_request != 0) begin
        gap = sink_hold_request;
        sink_hold_request = 0;
      end else if (gap == 0 && !quiet && sink_jitter && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offers one byte and waits for the transaction; valid stays up afterwards
  task automatic send_stream_byte(input logic [icy_md_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    sent_count++;
    if (sent_count % 32 == 0) sender_jitter = ($urandom_range(0, 2) != 0);
    if (!quiet && !sender_eager && sender_jitter && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_stream_byte(b);
  endtask

  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [icy_md_pkg::METAINT_W-1:0] value);
    await_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    interval_reg = value;
    restart_framing();
    cfg_we_i <= 1'b0;
  endtask

  // Sends a length byte and a block of that many units laid out as asked
  task automatic send_meta_block(input logic [icy_md_pkg::BYTE_W-1:0] units,
                                 input block_shape_e shape);
    logic [icy_md_pkg::BYTE_W-1:0] blk[];
    int unsigned n;
    int unsigned p;
    int unsigned klen;
    int unsigned clean_end;
    n = units * UNIT_BYTES;
    send_stream_byte(units);
    if (n == 0) return;
    blk = new[n];
    // Filler rich in key starts, quotes and semicolons
    foreach (blk[i]) begin
      case ($urandom_range(0, 9))
        0, 1:    blk[i] = 8'($urandom_range(0, 255));
        2:       blk[i] = icy_md_pkg::CHAR_S;
        3:       blk[i] = icy_md_pkg::CHAR_QUOTE;
        4:       blk[i] = icy_md_pkg::CHAR_SEMI;
        default: blk[i] = 8'($urandom_range(8'h61, 8'h7A));
      endcase
    end
    // Key position for each layout; a broken block gets only part of the key
    klen      = icy_md_pkg::KEY_LEN;
    clean_end = 0;
    case (shape)
      BLK_NO_KEY: begin
        klen = $urandom_range(1, icy_md_pkg::KEY_LEN - 1);
        p    = $urandom_range(0, n - klen);
      end
      BLK_EMPTY_TITLE, BLK_QUOTE_THEN_TEXT:
        p = $urandom_range(0, n - icy_md_pkg::KEY_LEN - 2);
      BLK_KEY_AT_END:    p = n - icy_md_pkg::KEY_LEN;
      BLK_REPEATED_KEY:  p = 0;
      BLK_QUOTE_AT_END:  p = $urandom_range(0, n - icy_md_pkg::KEY_LEN - 1);
      BLK_RESTARTED_KEY: p = $urandom_range(1, n - icy_md_pkg::KEY_LEN);
      default:           p = $urandom_range(0, n - icy_md_pkg::KEY_LEN);
    endcase
    for (int j = 0; j < klen; j++)
      blk[p + j] = TITLE_KEY[8*(icy_md_pkg::KEY_LEN-1-j) +: 8];
    // Bytes around the key
    case (shape)
      BLK_EMPTY_TITLE: begin
        blk[p + icy_md_pkg::KEY_LEN]     = icy_md_pkg::CHAR_QUOTE;
        blk[p + icy_md_pkg::KEY_LEN + 1] = icy_md_pkg::CHAR_SEMI;
      end
      BLK_REPEATED_KEY: begin
        blk[icy_md_pkg::KEY_LEN + 1] = icy_md_pkg::CHAR_QUOTE;
        blk[icy_md_pkg::KEY_LEN + 2] = icy_md_pkg::CHAR_SEMI;
        if (n >= 2 * UNIT_BYTES)
          for (int j = 0; j < icy_md_pkg::KEY_LEN; j++)
            blk[n - icy_md_pkg::KEY_LEN + j] = blk[j];
      end
      BLK_QUOTE_AT_END: begin
        clean_end  = n - 1;
        blk[n - 1] = icy_md_pkg::CHAR_QUOTE;
      end
      BLK_QUOTE_THEN_TEXT: begin
        clean_end  = n - 2;
        blk[n - 2] = icy_md_pkg::CHAR_QUOTE;
        blk[n - 1] = 8'($urandom_range(8'h61, 8'h7A));
      end
      BLK_RESTARTED_KEY: blk[p - 1] = icy_md_pkg::CHAR_S;
      default: ;
    endcase
    // For layouts with a quote near the end, keep the title open up to the tail of the block
    for (int unsigned i = p + icy_md_pkg::KEY_LEN; i < clean_end; i++)
      if (blk[i] == icy_md_pkg::CHAR_QUOTE) blk[i] = CHAR_DASH;
    foreach (blk[i]) send_stream_byte(blk[i]);
  endtask

  task automatic run_framed_phase(input logic [icy_md_pkg::METAINT_W-1:0] interval,
                                  input int unsigned blocks, input bit cut_short);
    logic [icy_md_pkg::BYTE_W-1:0] units;
    write_interval(interval);
    repeat (blocks) begin
      repeat (interval) send_stream_byte(8'($urandom));
      case ($urandom_range(0, 7))
        0:       units = 8'd0;
        1:       units = 8'd2;
        default: units = 8'd1;
      endcase
      send_meta_block(units, block_shape_e'($urandom_range(0, BLK_RESTARTED_KEY)));
    end
    // Stop part-way into a block so the next write has to clear it
    if (cut_short) begin
      repeat (interval) send_stream_byte(8'($urandom));
      send_stream_byte(8'd1);
      repeat ($urandom_range(1, 10)) send_stream_byte(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_passthrough_extremes();
    write_interval('0);
    send_stream_byte(8'h00);
    send_stream_byte(8'hFF);
    send_stream_byte(icy_md_pkg::CHAR_QUOTE);
  endtask

  // Out-of-range intervals pass through; the top legal one frames audio
  task automatic test_interval_limits();
    write_interval('1);
    send_stream_byte(8'hA5);
    write_interval(icy_md_pkg::METAINT_W'(METAINT_LIMIT + 1));
    send_stream_byte(8'h5A);
    write_interval(icy_md_pkg::METAINT_W'(METAINT_LIMIT));
    send_stream_byte(8'h01);
    send_stream_byte(8'hFE);
  endtask

  // Empty block, then one block with a properly terminated title
  task automatic test_title_directed();
    write_interval(icy_md_pkg::METAINT_W'(1));
    send_stream_byte(8'hC3);
    send_stream_byte(8'h00);
    send_stream_byte(8'h3C);
    send_stream_byte(8'h01);
    for (int j = 0; j < 16; j++) send_stream_byte(TITLE_BLOCK[8*(15-j) +: 8]);
  endtask

  task automatic test_passthrough_random();
    write_interval('0);
    repeat (24) send_stream_byte(8'($urandom));
  endtask

  task automatic test_block_shapes();
    write_interval(icy_md_pkg::METAINT_W'(1));
    for (int s = 0; s <= BLK_RESTARTED_KEY; s++) begin
      send_stream_byte(8'($urandom));
      send_meta_block(8'd1, block_shape_e'(s));
    end
    send_stream_byte(8'($urandom));
    send_meta_block(8'd2, BLK_REPEATED_KEY);
  endtask

  task automatic test_framed_random();
    for (int ph = 0; ph < 3; ph++)
      run_framed_phase(icy_md_pkg::METAINT_W'($urandom_range(1, 6)), 1, ph[0]);
    // Largest length byte; the block is cut short by the next register write
    write_interval(icy_md_pkg::METAINT_W'(1));
    send_stream_byte(8'($urandom));
    send_stream_byte(8'hFF);
    repeat (8) send_stream_byte(8'($urandom));
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    sender_eager = 1'b1;
    write_interval('0);
    sink_hold_request = 80;
    repeat (16) send_stream_byte(8'($urandom));
    write_interval(icy_md_pkg::METAINT_W'(1));
    sink_hold_request = 120;
    repeat (2) begin
      send_stream_byte(8'($urandom));
      send_meta_block(8'd1, BLK_QUOTE_THEN_TEXT);
    end
    sender_eager = 1'b0;
  endtask

  task automatic test_unthrottled_tail();
    quiet = 1'b1;
    run_framed_phase(icy_md_pkg::METAINT_W'(2), 2, 1'b0);
  endtask

  initial begin : main
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= '0;
    interval_reg = '0;
    restart_framing();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_extremes();
    test_interval_limits();
    test_title_directed();
    test_passthrough_random();
    test_block_shapes();
    test_framed_random();
    test_output_backpressure();
    test_unthrottled_tail();

    await_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> icy_metadata_deinterleaver.f
hdl/icy_md_pkg.sv
hdl/icy_md_parser.sv
hdl/icy_md_resq.sv
hdl/icy_metadata_deinterleaver.sv
sim/testbench.sv
